// ----- rtl/tpts_pkg.sv -----
// ----------------------------------------------------------------------------
// tpts_pkg: shared types and constants for the triangle projection block
// Coefficient and coordinate formats, configuration register codes, reset
// values and the word that travels between the transform and divide halves.
// ----------------------------------------------------------------------------
package tpts_pkg;

  // Arithmetic formats
  localparam int COEFF_WIDTH = 16;            // signed Q4.(COEFF_WIDTH-4)
  localparam int COORD_WIDTH = 32;            // internal clip-space register width
  localparam int COEFF_FRAC  = COEFF_WIDTH - 4;
  localparam int LANE_W      = 16;            // packing pitch of one coefficient
  localparam int ROW_W       = 4 * LANE_W;
  localparam int IN_W        = 32;            // world coordinates, Q16.16
  localparam int OUT_W       = 32;            // screen coordinates, Q16.16
  localparam int HALF_W      = 13;
  localparam int FRAC_BITS   = 16;            // Q16.16 fraction bits

  // Matrix products and their sum
  localparam int PRODM_W = COEFF_WIDTH + IN_W;
  localparam int SUM_W   = COEFF_WIDTH + IN_W + 3;
  localparam int ACC_W   = (SUM_W > COORD_WIDTH + 1) ? SUM_W : COORD_WIDTH + 1;
  localparam int CMP_W   = (COORD_WIDTH > IN_W) ? COORD_WIDTH : IN_W;

  // Divider
  localparam int DIV_STEP   = 4;
  localparam int NUM_W      = COORD_WIDTH + FRAC_BITS;
  localparam int DIV_STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int QUO_W      = DIV_STAGES * DIV_STEP;
  localparam int DIV_LAT    = DIV_STAGES + 1;

  // Viewport
  localparam int VP_W     = ((COORD_WIDTH > FRAC_BITS + 1) ? COORD_WIDTH : FRAC_BITS + 1) + 1;
  localparam int VPROD_W  = VP_W + HALF_W + 1;
  localparam int BACK_LAT = DIV_LAT + 2;

  // Queue between the halves
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // Matrix rows
  localparam int ROW_X = 0;
  localparam int ROW_Y = 1;
  localparam int ROW_Z = 2;
  localparam int ROW_WC = 3;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_X  = 3'd0,
    CFG_ROW_Y  = 3'd1,
    CFG_ROW_Z  = 3'd2,
    CFG_ROW_W  = 3'd3,
    CFG_Z_NEAR = 3'd4,
    CFG_HALF_W = 3'd5,
    CFG_HALF_H = 3'd6
  } cfg_idx_t;

  localparam logic [ROW_W-1:0]  ROW_X_RST  = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0]  ROW_Y_RST  = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0]  ROW_Z_RST  = 64'h0000_1000_0000_0000;
  localparam logic [ROW_W-1:0]  ROW_W_RST  = 64'h1000_0000_0000_0000;
  localparam logic [IN_W-1:0]   Z_NEAR_RST = '0;
  localparam logic [HALF_W-1:0] HALF_W_RST = 13'd320;
  localparam logic [HALF_W-1:0] HALF_H_RST = 13'd240;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PRODM_W-1:0]     prod_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic signed [CMP_W-1:0]       cmp_t;

  // |w| below one sixteenth leaves x and y undivided
  localparam coord_t W_MIN = coord_t'(4096);

  typedef struct packed {
    logic [3:0][ROW_W-1:0] row;
    logic signed [IN_W-1:0] z_near;
    logic [HALF_W-1:0]      half_w;
    logic [HALF_W-1:0]      half_h;
  } cfg_t;

  // One kept triangle in clip space, waiting for its divides
  typedef struct packed {
    coord_t [2:0] cx;
    coord_t [2:0] cy;
    coord_t [2:0] cw;
    logic   [2:0] byp;
  } tri_clip_t;

endpackage

// ----- rtl/tpts_ifs.sv -----
// ----------------------------------------------------------------------------
// tpts_ifs: channel interfaces of the triangle projection block
// Triangle input, screen result output and configuration write channels.
// ----------------------------------------------------------------------------
interface tpts_in_if;
  logic valid;
  logic ready;
  logic signed [tpts_pkg::IN_W-1:0] v0_x, v0_y, v0_z;
  logic signed [tpts_pkg::IN_W-1:0] v1_x, v1_y, v1_z;
  logic signed [tpts_pkg::IN_W-1:0] v2_x, v2_y, v2_z;

  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  input ready);
  modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  output ready);
endinterface

interface tpts_out_if;
  logic valid;
  logic ready;
  logic signed [tpts_pkg::OUT_W-1:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y;

  modport source (output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, input ready);
  modport sink   (input valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, output ready);
endinterface

interface tpts_cfg_if;
  logic valid;
  logic ready;
  logic [tpts_pkg::CFG_IDX_W-1:0] index;
  logic [tpts_pkg::ROW_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/tpts_div.sv -----
// ----------------------------------------------------------------------------
// tpts_div: pipelined Q16.16 divider
// Restoring division of |n| * 2^16 by |d|, a few quotient bits per stage,
// with sign restore, saturation and a bypass for small divisors.
// ----------------------------------------------------------------------------
module tpts_div (
  input  logic             clk,
  input  logic             en,
  input  tpts_pkg::coord_t n,
  input  tpts_pkg::coord_t d,
  input  logic             byp,
  output tpts_pkg::coord_t q
);

  localparam int W   = tpts_pkg::COORD_WIDTH;
  localparam int QW  = tpts_pkg::QUO_W;
  localparam int NST = tpts_pkg::DIV_STAGES;

  typedef struct packed {
    logic [W-1:0]     rem;
    logic [QW-1:0]    num;
    logic [QW-1:0]    quo;
    logic [W-1:0]     den;
    logic             neg;
    logic             byp;
    tpts_pkg::coord_t raw;
  } div_stage_t;

  div_stage_t       stg    [NST+1];
  div_stage_t       stg_r  [1:NST];
  tpts_pkg::coord_t res_r;
  logic [W-1:0]     mag_n;
  logic [W-1:0]     mag_d;

  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t   t;
    logic [W:0]   trial;
    t = s;
    for (int b = 0; b < tpts_pkg::DIV_STEP; b++) begin
      trial = {t.rem, t.num[QW-1]};
      t.num = {t.num[QW-2:0], 1'b0};
      if (trial >= {1'b0, t.den}) begin
        t.rem = W'(trial - {1'b0, t.den});
        t.quo = {t.quo[QW-2:0], 1'b1};
      end else begin
        t.rem = trial[W-1:0];
        t.quo = {t.quo[QW-2:0], 1'b0};
      end
    end
    return t;
  endfunction

  function automatic tpts_pkg::coord_t div_sat(input logic [QW-1:0] qv, input logic neg);
    logic big;
    big = (qv[QW-1:W-1] != '0);
    if (!neg) begin
      return big ? {1'b0, {(W-1){1'b1}}} : tpts_pkg::coord_t'(qv[W-1:0]);
    end
    // The most negative value is reachable exactly
    if (qv[QW-1:W] != '0 || (qv[W-1] && qv[W-2:0] != '0)) begin
      return {1'b1, {(W-1){1'b0}}};
    end
    return tpts_pkg::coord_t'(-qv[W-1:0]);
  endfunction

  assign mag_n = n[W-1] ? W'(-n) : W'(n);
  assign mag_d = d[W-1] ? W'(-d) : W'(d);

  always_comb begin
    stg[0].rem = '0;
    stg[0].num = QW'({mag_n, {tpts_pkg::FRAC_BITS{1'b0}}});
    stg[0].quo = '0;
    stg[0].den = mag_d;
    stg[0].neg = n[W-1] ^ d[W-1];
    stg[0].byp = byp;
    stg[0].raw = n;
  end

  for (genvar k = 1; k <= NST; k++) begin : g_stage
    assign stg[k] = stg_r[k];
    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k] <= div_step(stg[k-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= stg[NST].byp ? stg[NST].raw : div_sat(stg[NST].quo, stg[NST].neg);
    end
  end

  assign q = res_r;

endmodule

// ----- rtl/tpts_fifo.sv -----
// ----------------------------------------------------------------------------
// tpts_fifo: short queue of kept triangles
// Decouples the transform half from the divide half so each may stall alone.
// ----------------------------------------------------------------------------
module tpts_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  tpts_pkg::tri_clip_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output tpts_pkg::tri_clip_t pop_data
);

  localparam int PW = tpts_pkg::FIFO_PTR_W;

  tpts_pkg::tri_clip_t mem_r [tpts_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [PW:0]   cnt_r;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != (PW+1)'(tpts_pkg::FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/tpts_front.sv -----
// ----------------------------------------------------------------------------
// tpts_front: vertex transform and near-plane test
// Three stages: coefficient products, sums with rounding, then shift and
// saturate to clip space. Triangles failing the near test are dropped here.
// ----------------------------------------------------------------------------
module tpts_front (
  input  logic                clk,
  input  logic                rst_n,
  input  tpts_pkg::cfg_t      cfg,
  tpts_in_if.sink             in_ch,
  output logic                push_valid,
  input  logic                push_ready,
  output tpts_pkg::tri_clip_t push_data
);

  localparam int AW = tpts_pkg::ACC_W;
  localparam int CW = tpts_pkg::COORD_WIDTH;
  localparam tpts_pkg::acc_t RND = tpts_pkg::acc_t'(1) <<< (tpts_pkg::COEFF_FRAC - 1);

  logic signed [tpts_pkg::IN_W-1:0] vin [3][3];
  tpts_pkg::prod_t  prod_r [3][4][3];
  tpts_pkg::acc_t   acc_r  [3][4];
  tpts_pkg::coord_t clip_r [3][4];
  logic             v1_r, v2_r, v3_r;
  logic             en, keep;

  function automatic logic signed [tpts_pkg::COEFF_WIDTH-1:0] coeff(
    input logic [tpts_pkg::ROW_W-1:0] row, input int lane);
    return row[lane*tpts_pkg::LANE_W +: tpts_pkg::COEFF_WIDTH];
  endfunction

  function automatic tpts_pkg::coord_t sat_clip(input tpts_pkg::acc_t a);
    tpts_pkg::acc_t sh;
    sh = a >>> tpts_pkg::COEFF_FRAC;
    if (sh[AW-1:CW-1] == '0 || sh[AW-1:CW-1] == '1) begin
      return sh[CW-1:0];
    end
    return sh[AW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  assign vin[0][0] = in_ch.v0_x;
  assign vin[0][1] = in_ch.v0_y;
  assign vin[0][2] = in_ch.v0_z;
  assign vin[1][0] = in_ch.v1_x;
  assign vin[1][1] = in_ch.v1_y;
  assign vin[1][2] = in_ch.v1_z;
  assign vin[2][0] = in_ch.v2_x;
  assign vin[2][1] = in_ch.v2_y;
  assign vin[2][2] = in_ch.v2_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int r = 0; r < 4; r++) begin
          for (int j = 0; j < 3; j++) begin
            prod_r[i][r][j] <= tpts_pkg::prod_t'(coeff(cfg.row[r], j))
                             * tpts_pkg::prod_t'(vin[i][j]);
          end
          // Translation multiplies w = 1.0, which is a plain shift
          acc_r[i][r] <= tpts_pkg::acc_t'(prod_r[i][r][0]) + tpts_pkg::acc_t'(prod_r[i][r][1])
                       + tpts_pkg::acc_t'(prod_r[i][r][2])
                       + (tpts_pkg::acc_t'(coeff(cfg.row[r], 3)) <<< tpts_pkg::FRAC_BITS)
                       + RND;
          clip_r[i][r] <= sat_clip(acc_r[i][r]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_comb begin
    keep = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (tpts_pkg::cmp_t'(clip_r[i][tpts_pkg::ROW_Z]) < tpts_pkg::cmp_t'(cfg.z_near)) begin
        keep = 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      push_data.cx[i]  = clip_r[i][tpts_pkg::ROW_X];
      push_data.cy[i]  = clip_r[i][tpts_pkg::ROW_Y];
      push_data.cw[i]  = clip_r[i][tpts_pkg::ROW_WC];
      push_data.byp[i] = (clip_r[i][tpts_pkg::ROW_WC] < tpts_pkg::W_MIN)
                      && (clip_r[i][tpts_pkg::ROW_WC] > -tpts_pkg::W_MIN);
    end
  end

  // A dropped triangle never waits for queue space
  assign en          = !(v3_r && keep && !push_ready);
  assign push_valid  = v3_r && keep;
  assign in_ch.ready = en;

endmodule

// ----- rtl/tpts_back.sv -----
// ----------------------------------------------------------------------------
// tpts_back: perspective divide and viewport mapping
// Six pipelined dividers, one per screen coordinate, then the multiply by
// half the screen size and a saturating output register.
// ----------------------------------------------------------------------------
module tpts_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tpts_pkg::cfg_t      cfg,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  tpts_pkg::tri_clip_t pop_data,
  tpts_out_if.source          out_ch
);

  localparam int LAT = tpts_pkg::BACK_LAT;
  localparam int PW  = tpts_pkg::VPROD_W;
  localparam int OW  = tpts_pkg::OUT_W;

  typedef logic signed [tpts_pkg::VP_W-1:0] vp_t;
  typedef logic signed [PW-1:0]             vprod_t;

  logic [LAT:1]            vld_r;
  logic                    en;
  tpts_pkg::coord_t        dq     [6];
  vprod_t                  vprod_r[6];
  logic signed [OW-1:0]    scr_r  [6];

  function automatic logic signed [OW-1:0] sat_out(input vprod_t p);
    if (p[PW-1:OW-1] == '0 || p[PW-1:OW-1] == '1) begin
      return p[OW-1:0];
    end
    return p[PW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
  endfunction

  assign en        = !vld_r[LAT] || out_ch.ready;
  assign pop_ready = en;

  for (genvar g = 0; g < 6; g++) begin : g_lane
    logic [tpts_pkg::HALF_W-1:0] half;
    assign half = (g % 2 == 0) ? cfg.half_w : cfg.half_h;

    tpts_div u_div (
      .clk (clk),
      .en  (en),
      .n   ((g % 2 == 0) ? pop_data.cx[g/2] : pop_data.cy[g/2]),
      .d   (pop_data.cw[g/2]),
      .byp (pop_data.byp[g/2]),
      .q   (dq[g])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        vprod_r[g] <= vprod_t'(vp_t'(dq[g]) + vp_t'(1 << tpts_pkg::FRAC_BITS))
                    * vprod_t'($signed({1'b0, half}));
        scr_r[g]   <= sat_out(vprod_r[g]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-1:1], pop_valid};
    end
  end

  assign out_ch.valid = vld_r[LAT];
  assign out_ch.p0_x  = scr_r[0];
  assign out_ch.p0_y  = scr_r[1];
  assign out_ch.p1_x  = scr_r[2];
  assign out_ch.p1_y  = scr_r[3];
  assign out_ch.p2_x  = scr_r[4];
  assign out_ch.p2_y  = scr_r[5];

endmodule

// ----- rtl/triangle_project_to_screen.sv -----
// ----------------------------------------------------------------------------
// triangle_project_to_screen: world triangle to screen coordinates
// Holds the configuration registers and joins the transform half, the queue
// and the divide half.
// ----------------------------------------------------------------------------
//  Channel | Direction | Word
//  in_ch   | sink      | one triangle, three world vertices in Q16.16
//  out_ch  | source    | three screen vertices in Q16.16, saturated
//  cfg_ch  | sink      | register index and 64-bit data, always ready
//
//  One triangle is accepted per cycle while the queue has room; results
//  leave one per cycle while out_ch is ready. A triangle passes the
//  transform registers, the four-entry queue, the divider stages of four
//  quotient bits each and the viewport registers. An output stall holds the
//  back pipeline; the front keeps running until the queue is full.
//  Synchronous reset restores the identity matrix and a 640 by 480 screen.
// ----------------------------------------------------------------------------
module triangle_project_to_screen (
  input logic    clk,
  input logic    rst_n,
  tpts_in_if.sink     in_ch,
  tpts_out_if.source  out_ch,
  tpts_cfg_if.sink    cfg_ch
);

  tpts_pkg::cfg_t      cfg_r;
  logic                push_valid, push_ready, pop_valid, pop_ready;
  tpts_pkg::tri_clip_t push_data, pop_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row[tpts_pkg::ROW_X]  <= tpts_pkg::ROW_X_RST;
      cfg_r.row[tpts_pkg::ROW_Y]  <= tpts_pkg::ROW_Y_RST;
      cfg_r.row[tpts_pkg::ROW_Z]  <= tpts_pkg::ROW_Z_RST;
      cfg_r.row[tpts_pkg::ROW_WC] <= tpts_pkg::ROW_W_RST;
      cfg_r.z_near                <= tpts_pkg::Z_NEAR_RST;
      cfg_r.half_w                <= tpts_pkg::HALF_W_RST;
      cfg_r.half_h                <= tpts_pkg::HALF_H_RST;
    end else if (cfg_ch.valid) begin
      unique case (tpts_pkg::cfg_idx_t'(cfg_ch.index))
        tpts_pkg::CFG_ROW_X:  cfg_r.row[tpts_pkg::ROW_X]  <= cfg_ch.data;
        tpts_pkg::CFG_ROW_Y:  cfg_r.row[tpts_pkg::ROW_Y]  <= cfg_ch.data;
        tpts_pkg::CFG_ROW_Z:  cfg_r.row[tpts_pkg::ROW_Z]  <= cfg_ch.data;
        tpts_pkg::CFG_ROW_W:  cfg_r.row[tpts_pkg::ROW_WC] <= cfg_ch.data;
        tpts_pkg::CFG_Z_NEAR: cfg_r.z_near <= cfg_ch.data[tpts_pkg::IN_W-1:0];
        tpts_pkg::CFG_HALF_W: cfg_r.half_w <= cfg_ch.data[tpts_pkg::HALF_W-1:0];
        tpts_pkg::CFG_HALF_H: cfg_r.half_h <= cfg_ch.data[tpts_pkg::HALF_W-1:0];
        default: ;
      endcase
    end
  end

  tpts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tpts_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tpts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

// ----- test/triangle_project_to_screen_tb.sv -----
// ----------------------------------------------------------------------------
// triangle_project_to_screen_tb: self-checking bench for the projection block
// Sends triangles through the matrix transform, near rejection, divide and
// viewport mapping under several register settings, predicts each screen
// word and compares it field by field as results leave the block.
// ----------------------------------------------------------------------------
module triangle_project_to_screen_tb;

  typedef logic [8:0][31:0] tri_word_t;   // v0_x .. v2_z, index 0 is v0_x
  typedef logic [5:0][31:0] scr_word_t;   // p0_x .. p2_y, index 0 is p0_x

  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tpts_in_if  in_ch();
  tpts_out_if out_ch();
  tpts_cfg_if cfg_ch();

  triangle_project_to_screen u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor's copy of the registers
  logic [63:0] mat_row [4];
  logic signed [31:0] near_z;
  logic [12:0] half_wd, half_ht;

  scr_word_t screen_q[$];
  int mismatches = 0;
  int burst_left = 0;
  int stall_mode = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint lane_coeff(logic [63:0] row, int lane);
    logic signed [15:0] c;
    c = row[16*lane +: 16];
    return longint'(c);
  endfunction

  function automatic longint clip_coord(logic [63:0] row, longint x, longint y, longint z);
    longint acc;
    acc = lane_coeff(row, 0) * x + lane_coeff(row, 1) * y + lane_coeff(row, 2) * z
        + lane_coeff(row, 3) * 65536;
    acc = (acc + 2048) >>> tpts_pkg::COEFF_FRAC;
    return sat32(acc);
  endfunction

  function automatic longint q16_divide(longint n, longint d);
    logic neg;
    longint un, ud, q;
    neg = (n < 0) != (d < 0);
    un = (n < 0 ? -n : n) <<< 16;
    ud = d < 0 ? -d : d;
    q = un / ud;
    return sat32(neg ? -q : q);
  endfunction

  function automatic logic [31:0] to_pixels(longint v, logic [12:0] half);
    longint s;
    s = (v + 65536) * longint'({1'b0, half});
    return 32'(sat32(s));
  endfunction

  // Returns 1 when the triangle survives the near plane
  function automatic logic project_triangle(tri_word_t t, output scr_word_t r);
    longint x, y, z, cx, cy, cz, cw;
    logic kept;
    kept = 1'b1;
    for (int i = 0; i < 3; i++) begin
      x = longint'($signed(t[3*i]));
      y = longint'($signed(t[3*i+1]));
      z = longint'($signed(t[3*i+2]));
      cx = clip_coord(mat_row[tpts_pkg::ROW_X], x, y, z);
      cy = clip_coord(mat_row[tpts_pkg::ROW_Y], x, y, z);
      cz = clip_coord(mat_row[tpts_pkg::ROW_Z], x, y, z);
      cw = clip_coord(mat_row[tpts_pkg::ROW_WC], x, y, z);
      if (cz < longint'(near_z)) kept = 1'b0;
      if ((cw < 0 ? -cw : cw) >= 4096) begin
        cx = q16_divide(cx, cw);
        cy = q16_divide(cy, cw);
      end
      r[2*i]   = to_pixels(cx, half_wd);
      r[2*i+1] = to_pixels(cy, half_ht);
    end
    return kept;
  endfunction

  task automatic write_reg(tpts_pkg::cfg_idx_t idx, logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      tpts_pkg::CFG_ROW_X:  mat_row[tpts_pkg::ROW_X]  = value;
      tpts_pkg::CFG_ROW_Y:  mat_row[tpts_pkg::ROW_Y]  = value;
      tpts_pkg::CFG_ROW_Z:  mat_row[tpts_pkg::ROW_Z]  = value;
      tpts_pkg::CFG_ROW_W:  mat_row[tpts_pkg::ROW_WC] = value;
      tpts_pkg::CFG_Z_NEAR: near_z  = value[31:0];
      tpts_pkg::CFG_HALF_W: half_wd = value[12:0];
      tpts_pkg::CFG_HALF_H: half_ht = value[12:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // The sender runs in bursts; valid only drops when a gap is taken.
  task automatic send_triangle(tri_word_t t);
    int gap;
    scr_word_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    {in_ch.v2_z, in_ch.v2_y, in_ch.v2_x, in_ch.v1_z, in_ch.v1_y, in_ch.v1_x,
     in_ch.v0_z, in_ch.v0_y, in_ch.v0_x} <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    if (project_triangle(t, r)) screen_q.insert(screen_q.size(), r);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (screen_q.size() != 0) @(posedge clk);
    // Dropped triangles may still be in flight with no word to wait for.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3, 4: return $urandom_range(0, 32'h00FF_FFFF);
      default: return 32'($signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000);
    endcase
  endfunction

  function automatic logic [63:0] pick_row();
    logic [63:0] row;
    for (int l = 0; l < 4; l++)
      case ($urandom_range(0, 5))
        0: row[16*l +: 16] = $urandom();
        1: row[16*l +: 16] = 16'h0000;
        default: row[16*l +: 16] = 16'($urandom_range(0, 16383) - 8192);
      endcase
    return row;
  endfunction

  function automatic tri_word_t uniform_tri(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    return {z, y, x, z, y, x, z, y, x};
  endfunction

  task automatic test_reset_values();
    send_triangle({32'h0001_0000, 32'h0000_8000, 32'hFFFF_8000,
                   32'h0000_8000, 32'hFFFF_0000, 32'h0000_0000,
                   32'h0002_0000, 32'h0000_0000, 32'h0001_0000});
    send_triangle(uniform_tri(32'h0, 32'h0, 32'h0));
    send_triangle(uniform_tri(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    wait_idle();
  endtask

  task automatic test_near_reject();
    // One vertex behind the plane drops the triangle; the next one passes.
    send_triangle({32'hFFFF_FFFF, 32'h0, 32'h0, 32'h1000, 32'h0, 32'h0,
                   32'h1000, 32'h0, 32'h0});
    send_triangle(uniform_tri(32'h0001_0000, 32'h0, 32'h0));
    wait_idle();
    write_reg(tpts_pkg::CFG_Z_NEAR, 64'h0000_0000_7FFF_FFFF);
    send_triangle(uniform_tri(32'h0, 32'h0, 32'h7FFF_FFFF));
    send_triangle(uniform_tri(32'h0, 32'h0, 32'h7FFF_FFFE));
    wait_idle();
    write_reg(tpts_pkg::CFG_Z_NEAR, 64'h0000_0000_8000_0000);
  endtask

  task automatic test_small_w();
    // w taken from z, so vertices around one sixteenth cross the threshold.
    write_reg(tpts_pkg::CFG_ROW_W, 64'h0000_1000_0000_0000);
    send_triangle({32'h0000_1000, 32'h0001_0000, 32'h0002_0000,
                   32'h0000_0FFF, 32'h0001_0000, 32'hFFFF_0000,
                   32'hFFFF_F000, 32'h7FFF_FFFF, 32'h8000_0000});
    send_triangle({32'h0, 32'h0003_0000, 32'hFFFD_0000,
                   32'hFFFF_F001, 32'h0, 32'h0,
                   32'h0000_0001, 32'h0000_0001, 32'h0000_0001});
    wait_idle();
  endtask

  task automatic test_extreme_settings();
    write_reg(tpts_pkg::CFG_ROW_X, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(tpts_pkg::CFG_ROW_Y, 64'h8000_8000_8000_8000);
    write_reg(tpts_pkg::CFG_ROW_W, 64'h1000_0000_0000_0000);
    write_reg(tpts_pkg::CFG_HALF_W, 64'd8191);
    write_reg(tpts_pkg::CFG_HALF_H, 64'd0);
    send_triangle(uniform_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_triangle(uniform_tri(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_triangle(uniform_tri(32'hFFFF_FFFF, 32'h0, 32'h8000_0000));
    wait_idle();
    write_reg(tpts_pkg::CFG_ROW_X, 64'h0);
    write_reg(tpts_pkg::CFG_ROW_Y, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(tpts_pkg::CFG_ROW_Z, 64'h0);
    write_reg(tpts_pkg::CFG_HALF_W, 64'd4096);
    write_reg(tpts_pkg::CFG_HALF_H, 64'd1);
    send_triangle(uniform_tri(32'h5555_5555, 32'hAAAA_AAAA, 32'h0));
    send_triangle(uniform_tri(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF));
    wait_idle();
  endtask

  task automatic test_random_triangles();
    tri_word_t t;
    for (int phase = 0; phase < 8; phase++) begin
      for (int r = 0; r < 4; r++)
        write_reg(tpts_pkg::cfg_idx_t'(r), (phase == 0) ? 64'(4096) << (16 * r) : pick_row());
      case (phase % 3)
        0: write_reg(tpts_pkg::CFG_Z_NEAR, 64'h0000_0000_8000_0000);
        1: write_reg(tpts_pkg::CFG_Z_NEAR,
                     64'(32'($urandom_range(0, 32'h0080_0000)) - 32'h0100_0000));
        default: write_reg(tpts_pkg::CFG_Z_NEAR, 64'h0000_0000_FF00_0000);
      endcase
      write_reg(tpts_pkg::CFG_HALF_W, (phase == 3) ? 64'd8191 : 64'($urandom_range(0, 4096)));
      write_reg(tpts_pkg::CFG_HALF_H, (phase == 5) ? 64'd0 : 64'($urandom_range(0, 8191)));
      for (int n = 0; n < 210; n++) begin
        for (int k = 0; k < 9; k++) t[k] = pick_coord();
        send_triangle(t);
      end
      wait_idle();
    end
  endtask

  // Receiver stalls: long stretches always ready, random stalls, bursty stalls
  int stall_cnt = 0;
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 300 == 299) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 9) < 7);
      default: out_ch.ready <= (stall_cnt % 16) < 5;
    endcase
  end

  always @(posedge clk) begin
    scr_word_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.p2_y, out_ch.p2_x, out_ch.p1_y, out_ch.p1_x, out_ch.p0_y, out_ch.p0_x};
      if (screen_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected screen word %h", got);
      end else begin
        want = screen_q.pop_front();
        for (int f = 0; f < 6; f++)
          if (got[f] !== want[f]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field p%0d_%s: expected %h, got %h", f / 2, (f % 2) ? "y" : "x",
                       want[f], got[f]);
          end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.v0_x = '0; in_ch.v0_y = '0; in_ch.v0_z = '0;
    in_ch.v1_x = '0; in_ch.v1_y = '0; in_ch.v1_z = '0;
    in_ch.v2_x = '0; in_ch.v2_y = '0; in_ch.v2_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = tpts_pkg::CFG_ROW_X;
    cfg_ch.data = '0;
    out_ch.ready = 1'b1;
    mat_row[tpts_pkg::ROW_X] = tpts_pkg::ROW_X_RST;
    mat_row[tpts_pkg::ROW_Y] = tpts_pkg::ROW_Y_RST;
    mat_row[tpts_pkg::ROW_Z] = tpts_pkg::ROW_Z_RST;
    mat_row[tpts_pkg::ROW_WC] = tpts_pkg::ROW_W_RST;
    near_z = tpts_pkg::Z_NEAR_RST;
    half_wd = tpts_pkg::HALF_W_RST;
    half_ht = tpts_pkg::HALF_H_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_near_reject();
    test_small_w();
    test_extreme_settings();
    test_random_triangles();
    if (mismatches == 0 && screen_q.size() == 0) begin
      $display("triangle_project_to_screen_tb passed");
    end else begin
      $display("triangle_project_to_screen_tb failed");
    end
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("triangle_project_to_screen_tb failed");
    $finish;
  end

endmodule
